// ----- design/rsal_pkg.sv -----
package rsal_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [31:0] HOLD_TIMEOUT_RESET = 32'd900000;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] request;
  } slot_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t      wr_data;
  } ram_cmd_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] request_id;
    logic        take_lock;
    logic [31:0] release_token;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [31:0] granted_token;
    logic        expired_found;
    logic [15:0] expired_request;
    logic [3:0]  slots_free;
    logic        lock_held;
  } result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_status_t;

endpackage

// ----- design/rsal_slot_ram.sv -----
module rsal_slot_ram
  import rsal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ram_cmd_t    cmd,
  output slot_entry_t rd_data
);

  slot_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] written;
  slot_entry_t      rd_q;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        written[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_written <= written[cmd.rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

// ----- design/rsal_ctrl.sv -----
module rsal_ctrl
  import rsal_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  item_t        item_in,
  input  logic [31:0]  hold_timeout_ms,
  input  logic         res_take,
  input  slot_entry_t  rd_data,
  output ram_cmd_t     cmd,
  output ctrl_status_t status,
  output result_t      result
);

  scan_state_t      state, state_next;
  logic [IDX_W-1:0] idx;
  item_t            item;
  logic [CNT_W-1:0] free_count;
  logic [31:0]      lock_token;
  logic [31:0]      granted;
  logic             found;
  logic [15:0]      exp_req;

  logic        scanning;
  logic        last_slot;
  logic        hit_reserve;
  logic        hit_release;
  logic        hit_check;
  logic        finish;
  logic [31:0] stamp;
  logic [31:0] elapsed;

  assign scanning  = (state == ST_SCAN);
  assign last_slot = (idx == IDX_W'(SLOTS - 1));
  assign stamp     = (item.now_ms == 32'd0) ? 32'd1 : item.now_ms;
  assign elapsed   = item.now_ms - rd_data.start;

  assign hit_reserve = scanning && (item.opcode == OP_RESERVE) && (free_count != '0)
                       && (lock_token == 32'd0) && (rd_data.start == 32'd0);
  assign hit_release = scanning && (item.opcode == OP_RELEASE)
                       && (item.release_token != 32'd0)
                       && (rd_data.start == item.release_token);
  assign hit_check   = scanning && (item.opcode == OP_CHECK) && (rd_data.start != 32'd0)
                       && (elapsed > hold_timeout_ms);
  assign finish      = scanning && (last_slot || hit_reserve || hit_check);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (finish) state_next = ST_DONE;
      ST_DONE: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.rd_en           = (state == ST_IDLE && start) || (scanning && !finish);
    cmd.rd_addr         = (state == ST_IDLE) ? '0 : idx + 1'b1;
    cmd.wr_en           = hit_reserve || hit_release;
    cmd.wr_addr         = idx;
    cmd.wr_data.start   = hit_reserve ? stamp : 32'd0;
    cmd.wr_data.request = hit_reserve ? item.request_id : rd_data.request;
  end

  always_comb begin
    status.idle             = (state == ST_IDLE);
    status.res_valid        = (state == ST_DONE);
    result.granted_token    = granted;
    result.expired_found    = found;
    result.expired_request  = exp_req;
    result.slots_free       = 4'(free_count);
    result.lock_held        = (lock_token != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_count <= CNT_W'(SLOTS);
      lock_token <= 32'd0;
    end else begin
      state <= state_next;
      if (hit_reserve) begin
        free_count <= free_count - 1'b1;
        if (item.take_lock) begin
          lock_token <= stamp;
        end
      end
      if (hit_release) begin
        if (free_count < CNT_W'(SLOTS)) begin
          free_count <= free_count + 1'b1;
        end
        if (lock_token == item.release_token) begin
          lock_token <= 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      item    <= item_in;
      idx     <= '0;
      granted <= 32'd0;
      found   <= 1'b0;
      exp_req <= 16'd0;
    end else if (scanning) begin
      idx <= idx + 1'b1;
      if (hit_reserve) begin
        granted <= stamp;
      end
      if (hit_check) begin
        found   <= 1'b1;
        exp_req <= rd_data.request;
      end
    end
  end

endmodule

// ----- design/request_slot_allocator_with_lock.sv -----
// A new transaction is accepted only after the result of the previous one has been taken
// for output. Each transaction is handled by a scan that reads one slot per cycle from the
// single read port of the slot memory.
// Reset is synchronous and active high: all slots read as free, the free count is SLOTS,
// the lock is released and hold_timeout_ms returns to 900000. No clearing pass is needed.
module request_slot_allocator_with_lock
  import rsal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_id[15:0], take_lock[16], release_token[48:17], now_ms[80:49]
  input  logic [87:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // granted_token[31:0], expired_found[32], expired_request[48:33],
  // slots_free[52:49], lock_held[53]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]  hold_timeout_ms;
  item_t        item_in;
  ram_cmd_t     cmd;
  slot_entry_t  rd_data;
  ctrl_status_t status;
  result_t      result;
  logic         start;
  logic         res_take;
  logic         out_valid;
  logic [55:0]  out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout_ms <= HOLD_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_timeout_ms <= cfg_data;
    end
  end

  assign item_in.opcode        = opcode_t'(s_axis_tuser);
  assign item_in.request_id    = s_axis_tdata[15:0];
  assign item_in.take_lock     = s_axis_tdata[16];
  assign item_in.release_token = s_axis_tdata[48:17];
  assign item_in.now_ms        = s_axis_tdata[80:49];

  assign s_axis_tready = status.idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign res_take      = status.res_valid && (!out_valid || m_axis_tready);

  rsal_slot_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  rsal_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .item_in         (item_in),
    .hold_timeout_ms (hold_timeout_ms),
    .res_take        (res_take),
    .rd_data         (rd_data),
    .cmd             (cmd),
    .status          (status),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= {2'b00, result.lock_held, result.slots_free, result.expired_request,
                   result.expired_found, result.granted_token};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- design/rsal_checker.sv -----
module rsal_checker
  import rsal_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A result waiting for the sink keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[52:49] <= 4'(SLOTS))
    else $error("free count above slot count");

  a_grant_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> !m_axis_tdata[32])
    else $error("grant and expiry reported together");

  a_no_exp_req: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[48:33] == 16'd0)
    else $error("expired request id without expiry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while one is in progress");

endmodule

bind request_slot_allocator_with_lock rsal_checker u_rsal_checker (.*);

// ----- verif/tb.sv -----
module tb;
  import rsal_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = SLOTS + 3;
  localparam int LONG_HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // request_id[15:0], take_lock[16], release_token[48:17], now_ms[80:49]
  logic [87:0] s_axis_tdata = '0;
  // opcode[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // granted_token[31:0], expired_found[32], expired_request[48:33],
  // slots_free[52:49], lock_held[53]
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the slot table, the free count, the lock and the timeout.
  logic [31:0] held_since [SLOTS] = '{default: '0};
  logic [15:0] held_by [SLOTS] = '{default: '0};
  int          free_slots = SLOTS;
  logic [31:0] lock_owner = '0;
  logic [31:0] timeout_ms = HOLD_TIMEOUT_RESET;

  result_t     pending_results [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms = '0;

  request_slot_allocator_with_lock DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic result_t step_allocator(input item_t it);
    result_t     r;
    logic [31:0] stamp;
    logic        done;
    int          i;
    r = '0;
    done = 1'b0;
    stamp = (it.now_ms == 32'd0) ? 32'd1 : it.now_ms;
    case (it.opcode)
      OP_RESERVE: begin
        if (free_slots != 0 && lock_owner == 32'd0) begin
          for (i = 0; i < SLOTS; i++) begin
            if (!done && held_since[i] == 32'd0) begin
              held_since[i] = stamp;
              held_by[i] = it.request_id;
              free_slots--;
              if (it.take_lock) lock_owner = stamp;
              r.granted_token = stamp;
              done = 1'b1;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (it.release_token != 32'd0) begin
          for (i = 0; i < SLOTS; i++) begin
            if (held_since[i] == it.release_token) begin
              held_since[i] = 32'd0;
              if (free_slots < SLOTS) free_slots++;
              if (lock_owner == it.release_token) lock_owner = 32'd0;
            end
          end
        end
      end
      OP_CHECK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!done && held_since[i] != 32'd0 &&
              32'(it.now_ms - held_since[i]) > timeout_ms) begin
            r.expired_found = 1'b1;
            r.expired_request = held_by[i];
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.slots_free = 4'(free_slots);
    r.lock_held = (lock_owner != 32'd0);
    return r;
  endfunction

  // The receiver drives tready and checks every accepted result transaction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.granted_token) begin
          $error("granted_token: expected %0h, got %0h", want.granted_token,
                 m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[32] !== want.expired_found) begin
          $error("expired_found: expected %0d, got %0d", want.expired_found,
                 m_axis_tdata[32]);
          errors++;
        end
        if (m_axis_tdata[48:33] !== want.expired_request) begin
          $error("expired_request: expected %0h, got %0h", want.expired_request,
                 m_axis_tdata[48:33]);
          errors++;
        end
        if (m_axis_tdata[52:49] !== want.slots_free) begin
          $error("slots_free: expected %0d, got %0d", want.slots_free,
                 m_axis_tdata[52:49]);
          errors++;
        end
        if (m_axis_tdata[53] !== want.lock_held) begin
          $error("lock_held: expected %0d, got %0d", want.lock_held, m_axis_tdata[53]);
          errors++;
        end
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input opcode_t op, input logic [15:0] id, input logic lock,
                           input logic [31:0] tok, input logic [31:0] now);
    item_t it;
    it.opcode = op;
    it.request_id = id;
    it.take_lock = lock;
    it.release_token = tok;
    it.now_ms = now;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, now, tok, lock, id};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(step_allocator(it));
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    quiesce();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    timeout_ms = value;
  endtask

  task automatic send_random_item();
    int          pick;
    int          k;
    logic [31:0] tok;
    opcode_t     op;
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 400);
    pick = $urandom_range(99);
    if (pick < 40) op = OP_RESERVE;
    else if (pick < 72) op = OP_RELEASE;
    else if (pick < 94) op = OP_CHECK;
    else op = OP_NONE;
    tok = $urandom;
    pick = $urandom_range(99);
    k = $urandom_range(SLOTS - 1);
    if (pick < 10 && lock_owner != 32'd0) tok = lock_owner;
    else if (pick < 75 && held_since[k] != 32'd0) tok = held_since[k];
    else if (pick < 80) tok = '0;
    send_item(op, 16'($urandom), ($urandom_range(9) == 0), tok,
              ($urandom_range(99) == 0) ? 32'd0 : clock_ms);
  endtask

  task automatic run_traffic(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    repeat (count) send_random_item();
  endtask

  task automatic test_reserve_at_time_zero();
    send_item(OP_RESERVE, 16'h0000, 1'b0, 32'h0, 32'h0);
    send_item(OP_CHECK, 16'h0000, 1'b0, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 16'h0000, 1'b0, 32'h1, 32'h0);
  endtask

  task automatic test_lock();
    send_item(OP_RESERVE, 16'hFFFF, 1'b1, 32'h0, 32'd100);
    send_item(OP_RESERVE, 16'h1234, 1'b0, 32'h0, 32'd200);
    send_item(OP_CHECK, 16'h0000, 1'b0, 32'h0, 32'd150);
    send_item(OP_RELEASE, 16'h0000, 1'b0, 32'd100, 32'd300);
    send_item(OP_RELEASE, 16'hFFFF, 1'b1, 32'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_table();
    send_item(OP_RESERVE, 16'h0000, 1'b0, 32'h0, 32'd5);
    send_item(OP_RESERVE, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 32'd5);
    send_item(OP_RESERVE, 16'hA5A5, 1'b0, 32'h0, 32'd6);
    send_item(OP_RESERVE, 16'h5A5A, 1'b0, 32'h0, 32'd7);
    send_item(OP_RESERVE, 16'h0001, 1'b0, 32'h0, 32'd8);
    send_item(OP_RESERVE, 16'h8000, 1'b0, 32'h0, 32'd9);
    send_item(OP_RESERVE, 16'h00FF, 1'b0, 32'h0, 32'd10);
    send_item(OP_RESERVE, 16'hFF00, 1'b0, 32'h0, 32'd11);
    send_item(OP_RESERVE, 16'h4321, 1'b1, 32'h0, 32'd12);
    send_item(OP_RELEASE, 16'h0000, 1'b0, 32'd5, 32'd13);
    send_item(OP_NONE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_timeout_boundary();
    write_timeout(32'd10);
    send_item(OP_CHECK, 16'h0000, 1'b0, 32'h0, 32'd16);
    send_item(OP_CHECK, 16'h0000, 1'b0, 32'h0, 32'd17);
  endtask

  task automatic test_back_to_back();
    write_timeout(32'd1);
    run_traffic(110, 0, 0);
  endtask

  task automatic test_sender_gaps();
    write_timeout(32'hFFFF_FFFF);
    run_traffic(110, 49, 0);
  endtask

  task automatic test_receiver_stalls();
    write_timeout(32'($urandom_range(50, 3000)));
    run_traffic(40, 0, 49);
    hold_requests <= hold_requests + 1;
    run_traffic(30, 0, 49);
    quiesce();
    run_traffic(40, 0, 49);
  endtask

  task automatic test_both_idle();
    write_timeout(HOLD_TIMEOUT_RESET);
    run_traffic(110, 30, 30);
  endtask

  initial begin
    clock_ms = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reserve_at_time_zero();
    test_lock();
    test_full_table();
    test_timeout_boundary();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    quiesce();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rsal_pkg.sv
design/rsal_slot_ram.sv
design/rsal_ctrl.sv
design/request_slot_allocator_with_lock.sv
design/rsal_checker.sv
verif/tb.sv
